FILE: design/hdp_pkg.sv
// ----------------------------------------------------------------------------
// hdp_pkg
// Shared constants and controller/datapath interface types for the
// hypergeometric draw probability block.
// ----------------------------------------------------------------------------
package hdp_pkg;

    localparam int MAX_POOL     = 64;
    localparam int FRAC_BITS    = 32;
    localparam int CNT_W        = 7;
    localparam int PROB_W       = 33;
    localparam int BINOM_W      = 64;
    localparam int HALF_W       = BINOM_W / 2;
    localparam int ROW_LEN      = MAX_POOL + 1;
    localparam int PASCAL_DEPTH = ROW_LEN * ROW_LEN;
    localparam int ADDR_W       = $clog2(PASCAL_DEPTH);
    localparam int DIV_CNT_W    = $clog2(FRAC_BITS + 1);

    typedef enum logic [2:0] {
        ASEL_FILL_RD = 3'd0,
        ASEL_FILL_WR = 3'd1,
        ASEL_DEN     = 3'd2,
        ASEL_A       = 3'd3,
        ASEL_B       = 3'd4
    } addr_sel_t;

    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_HL = 2'd1,
        MUL_LH = 2'd2
    } mul_step_t;

    typedef struct packed {
        logic      load;
        logic      fill_wr;
        logic      check;
        logic      den_cap;
        logic      a_cap;
        logic      b_cap;
        logic      mul_en;
        mul_step_t mul_step;
        logic      term_add;
        logic      div_init;
        logic      div_step;
        addr_sel_t addr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic early;
        logic loop_more;
        logic div_done;
    } dp_status_t;

endpackage

FILE: design/hypergeometric_draw_probability_top.sv
// ----------------------------------------------------------------------------
// hypergeometric_draw_probability_top
// Exact hypergeometric probability (exactly or at least) in Q1.32.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------------------
//   request   | start, busy         | pool_size, draw_count, target_count,
//             |                     | needed_count, exact_mode
//   result    | done (one cycle)    | probability
//
// After reset a Pascal triangle of 2145 entries (rows 0 to 64) is built in RAM,
// each entry with a read state then a write state; busy stays high until it
// is complete. A request answered by the early checks goes from the check state
// straight to done; otherwise the denominator is read, then for each summed
// term come RAM reads, three 32x32 partial products and an accumulate, then
// bit-serial division and a result state.
// The result is shown for one cycle on done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module hypergeometric_draw_probability_top
    import hdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CNT_W-1:0]  pool_size,
    input  logic [CNT_W-1:0]  draw_count,
    input  logic [CNT_W-1:0]  target_count,
    input  logic [CNT_W-1:0]  needed_count,
    input  logic              exact_mode,
    output logic              done,
    output logic [PROB_W-1:0] probability
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hdp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    hdp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pool_size    (pool_size),
        .draw_count   (draw_count),
        .target_count (target_count),
        .needed_count (needed_count),
        .exact_mode   (exact_mode),
        .probability  (probability)
    );

endmodule

FILE: design/hdp_ram.sv
// ----------------------------------------------------------------------------
// hdp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hdp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4225
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/hdp_dp.sv
// ----------------------------------------------------------------------------
// hdp_dp
// Datapath: Pascal triangle store, term multiplier, accumulator and
// bit-serial fixed-point divider.
// ----------------------------------------------------------------------------
module hdp_dp
    import hdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [CNT_W-1:0]  pool_size,
    input  logic [CNT_W-1:0]  draw_count,
    input  logic [CNT_W-1:0]  target_count,
    input  logic [CNT_W-1:0]  needed_count,
    input  logic              exact_mode,
    output logic [PROB_W-1:0] probability
);

    localparam logic [PROB_W-1:0] ONE = PROB_W'(1) << FRAC_BITS;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [CNT_W-1:0] n,
                                                   input logic [CNT_W-1:0] k);
        row_addr = ADDR_W'(n) * ADDR_W'(ROW_LEN) + ADDR_W'(k);
    endfunction

    // fill counters, reset so the triangle build starts after reset
    logic [CNT_W-1:0]   fill_n_reg, fill_n_next;
    logic [CNT_W-1:0]   fill_k_reg, fill_k_next;
    logic [BINOM_W-1:0] prev_reg;

    logic [CNT_W-1:0]   total_reg, draw_reg, outs_reg, need_reg;
    logic               only_reg;
    logic [BINOM_W-1:0] den_reg, a_reg, b_reg, prod_reg, num_reg, rem_reg;
    logic [PROB_W-1:0]  q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [ADDR_W-1:0]  addr;
    logic [BINOM_W-1:0] rdata, wdata;
    logic               is_zero, is_over, early;
    logic [PROB_W-1:0]  early_value;
    logic [HALF_W-1:0]  mul_x, mul_y;
    logic [BINOM_W-1:0] mul_p;
    logic [BINOM_W-1:0] rem_shift;
    logic [CNT_W-1:0]   rest_n, rest_k;

    assign rest_n = total_reg - outs_reg;
    assign rest_k = draw_reg - need_reg;

    always_comb
    begin
        case (cmd.addr_sel)
            ASEL_FILL_RD: addr = row_addr(fill_n_reg - CNT_W'(1), fill_k_reg);
            ASEL_FILL_WR: addr = row_addr(fill_n_reg, fill_k_reg);
            ASEL_DEN:     addr = row_addr(total_reg, draw_reg);
            ASEL_A:       addr = row_addr(outs_reg, need_reg);
            ASEL_B:       addr = row_addr(rest_n, rest_k);
            default:      addr = '0;
        endcase
    end

    // edges of each row are one, inner entries sum the two above
    assign wdata = (fill_k_reg == '0 || fill_k_reg == fill_n_reg) ?
                   BINOM_W'(1) : rdata + prev_reg;

    hdp_ram #(
        .WIDTH (BINOM_W),
        .DEPTH (PASCAL_DEPTH)
    ) u_pascal (
        .clk   (clk),
        .we    (cmd.fill_wr),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        fill_n_next = fill_n_reg;
        fill_k_next = fill_k_reg;
        if (cmd.fill_wr)
        begin
            if (fill_k_reg == fill_n_reg)
            begin
                fill_n_next = fill_n_reg + CNT_W'(1);
                fill_k_next = '0;
            end
            else
            begin
                fill_k_next = fill_k_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_n_reg <= '0;
            fill_k_reg <= '0;
        end
        else
        begin
            fill_n_reg <= fill_n_next;
            fill_k_reg <= fill_k_next;
        end
    end

    // early outcomes
    always_comb
    begin
        is_zero = total_reg == '0 || draw_reg == '0 || outs_reg == '0 ||
                  need_reg > total_reg || need_reg > draw_reg ||
                  need_reg > outs_reg;
        is_over = draw_reg > total_reg || outs_reg > total_reg;
        early       = 1'b1;
        early_value = '0;
        if (is_zero)
        begin
            early_value = '0;
        end
        else if (is_over)
        begin
            early_value = (outs_reg > need_reg && only_reg) ? '0 : ONE;
        end
        else if (total_reg > CNT_W'(MAX_POOL))
        begin
            early_value = '0;
        end
        else if (need_reg == '0 && !only_reg)
        begin
            early_value = ONE;
        end
        else
        begin
            early = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.mul_step)
            MUL_LL:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
            MUL_HL:
            begin
                mul_x = a_reg[BINOM_W-1:HALF_W];
                mul_y = b_reg[HALF_W-1:0];
            end
            MUL_LH:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[BINOM_W-1:HALF_W];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p     = BINOM_W'(mul_x) * BINOM_W'(mul_y);
    assign rem_shift = rem_reg << 1;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            prev_reg <= (fill_k_reg == '0) ? BINOM_W'(1) : rdata;
        end
        if (cmd.load)
        begin
            total_reg <= pool_size;
            draw_reg  <= draw_count;
            outs_reg  <= target_count;
            need_reg  <= needed_count;
            only_reg  <= exact_mode;
            num_reg   <= '0;
        end
        if (cmd.check)
        begin
            if (early)
            begin
                q_reg <= early_value;
            end
            else if (need_reg == '0)
            begin
                // exactly zero wanted: all draws come from the unwanted ones
                outs_reg <= total_reg - outs_reg;
                need_reg <= draw_reg;
            end
        end
        if (cmd.den_cap)
        begin
            den_reg <= rdata;
        end
        if (cmd.a_cap)
        begin
            // needing more than outs_reg items gives no way at all
            a_reg <= (need_reg > outs_reg) ? '0 : rdata;
        end
        if (cmd.b_cap)
        begin
            b_reg <= (rest_k > rest_n) ? '0 : rdata;
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_step == MUL_LL)
            begin
                prod_reg <= mul_p;
            end
            else
            begin
                prod_reg <= prod_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end
        if (cmd.term_add)
        begin
            num_reg  <= num_reg + prod_reg;
            need_reg <= need_reg + CNT_W'(1);
        end
        if (cmd.div_init)
        begin
            if (num_reg >= den_reg)
            begin
                q_reg   <= ONE;
                cnt_reg <= '0;
            end
            else
            begin
                q_reg   <= '0;
                rem_reg <= num_reg;
                cnt_reg <= DIV_CNT_W'(FRAC_BITS);
            end
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (rem_shift >= den_reg)
            begin
                rem_reg <= rem_shift - den_reg;
                q_reg   <= {q_reg[PROB_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                q_reg   <= {q_reg[PROB_W-2:0], 1'b0};
            end
        end
    end

    assign status.fill_last = fill_n_reg == CNT_W'(MAX_POOL) && fill_k_reg == fill_n_reg;
    assign status.early     = early;
    assign status.loop_more = !only_reg && need_reg < draw_reg && need_reg < outs_reg;
    assign status.div_done  = cnt_reg == '0;
    assign probability      = q_reg;

endmodule

FILE: design/hdp_ctrl.sv
// ----------------------------------------------------------------------------
// hdp_ctrl
// Controller: builds the Pascal triangle after reset, then sequences the
// check, term loop and division of each transaction.
// ----------------------------------------------------------------------------
module hdp_ctrl
    import hdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_FILL_RD  = 16'h0002,
        ST_FILL_WR  = 16'h0004,
        ST_CHECK    = 16'h0008,
        ST_DEN_RD   = 16'h0010,
        ST_DEN_CAP  = 16'h0020,
        ST_A_RD     = 16'h0040,
        ST_B_RD     = 16'h0080,
        ST_B_CAP    = 16'h0100,
        ST_MUL_LL   = 16'h0200,
        ST_MUL_HL   = 16'h0400,
        ST_MUL_LH   = 16'h0800,
        ST_ACC      = 16'h1000,
        ST_DIV_INIT = 16'h2000,
        ST_DIV      = 16'h4000,
        ST_DONE     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = ASEL_FILL_RD;
        cmd.mul_step = MUL_LL;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.addr_sel = ASEL_FILL_WR;
                cmd.fill_wr  = 1'b1;
                state_next   = status.fill_last ? ST_IDLE : ST_FILL_RD;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.early ? ST_DONE : ST_DEN_RD;
            end
            ST_DEN_RD:
            begin
                cmd.addr_sel = ASEL_DEN;
                state_next   = ST_DEN_CAP;
            end
            ST_DEN_CAP:
            begin
                cmd.den_cap = 1'b1;
                state_next  = ST_A_RD;
            end
            ST_A_RD:
            begin
                cmd.addr_sel = ASEL_A;
                state_next   = ST_B_RD;
            end
            ST_B_RD:
            begin
                cmd.a_cap    = 1'b1;
                cmd.addr_sel = ASEL_B;
                state_next   = ST_B_CAP;
            end
            ST_B_CAP:
            begin
                cmd.b_cap  = 1'b1;
                state_next = ST_MUL_LL;
            end
            ST_MUL_LL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MUL_LL;
                state_next   = ST_MUL_HL;
            end
            ST_MUL_HL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MUL_HL;
                state_next   = ST_MUL_LH;
            end
            ST_MUL_LH:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MUL_LH;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.term_add = 1'b1;
                state_next   = status.loop_more ? ST_A_RD : ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL_RD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_DONE;

endmodule
